// ===== hw/rtl/spi_command_frame_parser_assert.svh =====
// Assertion macros used by the top-level RTL of the command frame parser.
`ifndef SPI_COMMAND_FRAME_PARSER_ASSERT_SVH
`define SPI_COMMAND_FRAME_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCFP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/scfp_pkg.sv =====
`default_nettype none

package scfp_pkg;

   localparam int unsigned BODY_LEN = 9;
   localparam int unsigned IDX_W    = $clog2(BODY_LEN);

   localparam logic [IDX_W-1:0] BODY_FIRST = IDX_W'(0);
   localparam logic [IDX_W-1:0] BODY_LAST  = IDX_W'(BODY_LEN - 1);

   localparam logic [7:0] CHAR_M     = 8'h4D;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_AMP   = 8'h26;

   // Element 0 is the first byte of the frame body.
   typedef logic [0:BODY_LEN-1][7:0] body_type;

   localparam body_type CMD_SET = "+SET+RBT&";
   localparam body_type CMD_CLR = "+CLR+RBT&";

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic       frame_done;
      logic [1:0] command_kind;
   } result_type;

   function automatic logic [1:0] classify(input body_type body);
      logic [1:0] kind;
      kind = KIND_OTHER;
      if (body == CMD_SET) begin
         kind = KIND_SET;
      end else if (body == CMD_CLR) begin
         kind = KIND_CLEAR;
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scfp_req_if.sv =====
`default_nettype none

interface scfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scfp_rsp_if.sv =====
`default_nettype none

interface scfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_done;
   logic [1:0] command_kind;

   modport source (output valid, output frame_done, output command_kind, input ready);
   modport sink   (input valid, input frame_done, input command_kind, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scfp_core.sv =====
`default_nettype none

// Header hunt, body store and command compare. The state advances on step.
module scfp_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           rx_byte,
   output scfp_pkg::result_type      result
);

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_EXPECT_A,
      ST_EXPECT_S,
      ST_BODY
   } state_type;

   state_type                         state_ff, state_in;
   logic [scfp_pkg::IDX_W-1:0]        idx_ff, idx_in;
   scfp_pkg::body_type                body_ff, body_in;
   scfp_pkg::body_type                candidate;
   logic                              close;
   logic                              bad_start;

   always_comb begin
      candidate = body_ff;
      if (state_ff == ST_BODY) begin
         candidate[idx_ff] = rx_byte;
      end
      bad_start = (idx_ff == scfp_pkg::BODY_FIRST) && (rx_byte != scfp_pkg::CHAR_PLUS);
      close     = (state_ff == ST_BODY) && !bad_start &&
                  ((idx_ff == scfp_pkg::BODY_LAST) || (rx_byte == scfp_pkg::CHAR_AMP));

      result.frame_done   = close;
      result.command_kind = close ? scfp_pkg::classify(candidate) : scfp_pkg::KIND_OTHER;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      body_in  = body_ff;
      case (state_ff)
         ST_EXPECT_A: begin
            state_in = (rx_byte == scfp_pkg::CHAR_A) ? ST_EXPECT_S : ST_HUNT;
         end
         ST_EXPECT_S: begin
            state_in = (rx_byte == scfp_pkg::CHAR_S) ? ST_BODY : ST_HUNT;
            idx_in   = scfp_pkg::BODY_FIRST;
         end
         ST_BODY: begin
            if (bad_start) begin
               state_in = ST_HUNT;
            end else if (close) begin
               // The store is cleared so a short next frame compares against zeros.
               state_in = ST_HUNT;
               body_in  = '0;
            end else begin
               body_in  = candidate;
               idx_in   = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = (rx_byte == scfp_pkg::CHAR_M) ? ST_EXPECT_A : ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         idx_ff   <= scfp_pkg::BODY_FIRST;
         body_ff  <= '0;
      end else if (step) begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         body_ff  <= body_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/spi_command_frame_parser.sv =====
// Command frame parser for bytes received over a serial link. Each beat on
// req_chan carries one received byte, and every byte yields exactly one beat
// on rsp_chan, in order. The parser hunts for the header "MAS"; a wrong header
// byte sends it back to the hunt without that byte being checked again as 'M'.
// The first body byte must be '+', else the parser returns to the hunt. Up to
// nine body bytes are collected, and the frame closes on '&' or on the ninth
// byte. The closing beat reports frame_done = 1 and command_kind 1 for
// "+SET+RBT&", 2 for "+CLR+RBT&" and 0 for anything else; all other beats
// report zeros. Throughput is one byte per clock cycle while rsp_chan does
// not stall. A byte is captured in the input register, processed by the core
// once the result register has room, and presented on rsp_chan from the
// result register. req_chan.ready drops only while both registers hold a
// beat and rsp_chan stalls. There is no initialization sweep after reset.

`default_nettype none

`include "spi_command_frame_parser_assert.svh"

module spi_command_frame_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   scfp_req_if.sink   req_chan,
   scfp_rsp_if.source rsp_chan
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   scfp_pkg::result_type out_ff, out_in;

   scfp_pkg::result_type core_result;
   logic                 out_free;
   logic                 step;
   logic                 accept;

   // The result register can take a new beat when it is empty or being drained.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   // A held byte is processed whenever the result register has room.
   assign step     = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign accept   = req_chan.valid && req_chan.ready;

   scfp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_in       = core_result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.frame_done   = out_ff.frame_done;
   assign rsp_chan.command_kind = out_ff.command_kind;

   // A byte waiting behind a stalled result must stay put until processed.
   `SCFP_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !out_free, in_valid_ff && $stable(in_byte_ff), "held input byte was lost or changed")

   // Every processed byte lands in the result register with the core's verdict.
   `SCFP_ASSERT_NEXT(a_step_result, clock, reset, step, out_valid_ff && (out_ff == $past(core_result)), "processed byte did not reach the result register")

   // A command kind is only reported on a frame-closing beat.
   `SCFP_ASSERT_IMPLIES(a_kind_needs_done, clock, reset, rsp_chan.valid && (rsp_chan.command_kind != scfp_pkg::KIND_OTHER), rsp_chan.frame_done, "command kind without a closed frame")

   // The reserved kind code never appears.
   `SCFP_ASSERT_IMPLIES(a_kind_legal, clock, reset, rsp_chan.valid, (rsp_chan.command_kind == scfp_pkg::KIND_OTHER) || (rsp_chan.command_kind == scfp_pkg::KIND_SET) || (rsp_chan.command_kind == scfp_pkg::KIND_CLEAR), "reserved command kind reported")

endmodule

`default_nettype wire

// ===== bench/tb_spi_command_frame_parser.sv =====
`default_nettype none

// Tracks the parser state from the accepted bytes and keeps the results that
// are still owed by the block, oldest first.
class frame_ledger;
   typedef enum {HUNT_M, EXPECT_A, EXPECT_S, IN_BODY} parse_phase_type;

   parse_phase_type         phase;
   int unsigned             body_idx;
   scfp_pkg::body_type      body;
   scfp_pkg::result_type    owed[$];
   int unsigned             mismatches;
   int unsigned             bytes_seen;
   int unsigned             frames_closed;
   int unsigned             set_frames;
   int unsigned             clear_frames;

   function new();
      phase         = HUNT_M;
      body_idx      = 0;
      body          = '0;
      mismatches    = 0;
      bytes_seen    = 0;
      frames_closed = 0;
      set_frames    = 0;
      clear_frames  = 0;
   endfunction

   // Advances the parser by one accepted byte and queues the result it owes.
   function void note_byte(logic [7:0] rx);
      scfp_pkg::result_type r;
      r = '0;
      bytes_seen++;
      case (phase)
         EXPECT_A: begin
            phase = (rx == scfp_pkg::CHAR_A) ? EXPECT_S : HUNT_M;
         end
         EXPECT_S: begin
            phase    = (rx == scfp_pkg::CHAR_S) ? IN_BODY : HUNT_M;
            body_idx = 0;
         end
         IN_BODY: begin
            if (body_idx == 0 && rx != scfp_pkg::CHAR_PLUS) begin
               phase = HUNT_M;
            end else begin
               body[body_idx] = rx;
               if (body_idx == scfp_pkg::BODY_LEN - 1 || rx == scfp_pkg::CHAR_AMP) begin
                  r.frame_done = 1'b1;
                  if (body == scfp_pkg::CMD_SET) begin
                     r.command_kind = scfp_pkg::KIND_SET;
                     set_frames++;
                  end else if (body == scfp_pkg::CMD_CLR) begin
                     r.command_kind = scfp_pkg::KIND_CLEAR;
                     clear_frames++;
                  end else begin
                     r.command_kind = scfp_pkg::KIND_OTHER;
                  end
                  frames_closed++;
                  body  = '0;
                  phase = HUNT_M;
               end else begin
                  body_idx++;
               end
            end
         end
         default: begin
            phase = (rx == scfp_pkg::CHAR_M) ? EXPECT_A : HUNT_M;
         end
      endcase
      owed.push_back(r);
   endfunction

   function void check_result(logic done, logic [1:0] kind);
      scfp_pkg::result_type want;
      if (owed.size() == 0) begin
         $error("result beat with nothing owed: frame_done=%0d command_kind=%0d",
                done, kind);
         mismatches++;
      end else begin
         want = owed.pop_front();
         if (done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, done);
            mismatches++;
         end
         if (kind !== want.command_kind) begin
            $error("command_kind: expected %0d, got %0d", want.command_kind, kind);
            mismatches++;
         end
      end
   endfunction
endclass

module tb_spi_command_frame_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_BYTES = 1600;

   logic clock;
   logic reset;

   scfp_req_if req_chan();
   scfp_rsp_if rsp_chan();

   spi_command_frame_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   frame_ledger ledger = new();

   // While set, neither side inserts idle cycles, so the parser sees a long
   // back-to-back run of bytes with the result side always ready.
   bit steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset is asserted from time zero and then released for good.
   initial begin
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Result side: ready drops with a chance of nine in a hundred. A beat is
   // taken when valid and ready were both high at this edge, which is what the
   // values read here reflect, since all updates land in the NBA region.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            ledger.check_result(rsp_chan.frame_done, rsp_chan.command_kind);
         end
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 9);
      end
   end

   // Presents one byte and holds it until the block takes it. Idle cycles are
   // inserted ahead of the byte by lowering valid for whole cycles, so valid
   // is never lowered and raised within one time step.
   task automatic send_byte(input logic [7:0] rx);
      while (!steady && $urandom_range(0, 99) < 9) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= rx;
      do @(posedge clock); while (!req_chan.ready);
      ledger.note_byte(rx);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   // Any byte except the one that closes a frame early.
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == scfp_pkg::CHAR_AMP);
      return b;
   endfunction

   // Noise between frames leans on the characters that steer the parser, so
   // partial headers and stray terminators show up often.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      case ($urandom_range(0, 5))
         0: b = scfp_pkg::CHAR_M;
         1: b = scfp_pkg::CHAR_A;
         2: b = scfp_pkg::CHAR_S;
         3: b = scfp_pkg::CHAR_PLUS;
         4: b = scfp_pkg::CHAR_AMP;
         default: b = 8'($urandom_range(0, 255));
      endcase
      return b;
   endfunction

   // Builds one framed command with a random body and sends it, now and then
   // with one byte anywhere in the frame replaced to break it.
   task automatic send_random_frame();
      logic [7:0]          fb[$];
      scfp_pkg::body_type  cmd;
      int unsigned         len;
      int unsigned         pick;
      fb   = '{scfp_pkg::CHAR_M, scfp_pkg::CHAR_A, scfp_pkg::CHAR_S};
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         // A real command, or one with a single body byte changed.
         cmd = ($urandom_range(0, 1) != 0) ? scfp_pkg::CMD_SET : scfp_pkg::CMD_CLR;
         if (pick >= 50) begin
            cmd[$urandom_range(1, scfp_pkg::BODY_LEN - 1)] = text_byte();
         end
         for (int i = 0; i < scfp_pkg::BODY_LEN; i++) begin
            fb.push_back(cmd[i]);
         end
      end else begin
         // A body of random length: two to eight bytes end on '&', a lone '+' is
         // left open, and nine close on the ninth byte whatever it holds.
         len = $urandom_range(1, scfp_pkg::BODY_LEN);
         fb.push_back(scfp_pkg::CHAR_PLUS);
         for (int i = 1; i < len - 1; i++) begin
            fb.push_back(text_byte());
         end
         if (len > 1) begin
            fb.push_back((len < scfp_pkg::BODY_LEN) ? scfp_pkg::CHAR_AMP
                                                    : 8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 99) < 12) begin
         fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom_range(0, 255));
      end
      repeat ($urandom_range(0, 2)) send_byte(noise_byte());
      foreach (fb[i]) begin
         send_byte(fb[i]);
      end
   endtask

   initial begin
      int unsigned start_count;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      @(negedge reset);
      @(posedge clock);

      // Directed part. A full set command; a repeated 'M' that must not be
      // taken as a fresh header start, so "AS" after it is ignored; a wrong
      // third header byte at the top of the byte range; a first body byte
      // that is not '+', at the bottom of the range; and a frame closed
      // early by '&', which must report other.
      send_text("MAS+SET+RBT&");
      send_text("MMAS");
      send_text("MA");
      send_byte(8'hFF);
      send_text("MAS");
      send_byte(8'h00);
      send_text("MAS+&");

      // Random part, with a stretch in the middle where nobody idles.
      start_count = ledger.bytes_seen;
      while (ledger.bytes_seen - start_count < RANDOM_BYTES) begin
         steady = (ledger.bytes_seen - start_count >= 700) &&
                  (ledger.bytes_seen - start_count < 1000);
         if ($urandom_range(0, 99) < 85) begin
            send_random_frame();
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      // Every byte owes one result; drain them and then leave a few cycles
      // for anything unexpected to surface.
      while (ledger.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes; %0d frames closed, %0d set and %0d clear commands.",
               ledger.bytes_seen, ledger.frames_closed, ledger.set_frames,
               ledger.clear_frames);
      if (ledger.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Timed out with %0d results still owed.", ledger.owed.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
